>>> rtl/hpfd_pkg.sv
// ----------------------------------------------------------------------------
// Hook point falloff deform - shared package
// Field widths, register indexes, falloff mode codes and the sideband types
// that travel with a point through the pipeline.
// ----------------------------------------------------------------------------
package hpfd_pkg;

  localparam int PosW = 21;   // Q12.8 position lane
  localparam int WgtW = 17;   // Q1.15 signed weight
  localparam int RegW = 63;   // widest configuration register
  localparam int RadW = 20;   // radius width
  localparam int StrW = 16;   // strength width
  localparam int IdxW = 3;    // register index width

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_MODE   = 3'd0;
  localparam logic [IdxW-1:0] REG_RADIUS = 3'd1;
  localparam logic [IdxW-1:0] REG_STRENGTH = 3'd2;
  localparam logic [IdxW-1:0] REG_CENTER = 3'd3;
  localparam logic [IdxW-1:0] REG_ROW_X  = 3'd4;
  localparam logic [IdxW-1:0] REG_ROW_Y  = 3'd5;
  localparam logic [IdxW-1:0] REG_ROW_Z  = 3'd6;
  localparam logic [IdxW-1:0] REG_OFFSET = 3'd7;

  // Falloff modes
  localparam logic [2:0] MODE_NONE   = 3'd0;
  localparam logic [2:0] MODE_CONST  = 3'd1;
  localparam logic [2:0] MODE_LINEAR = 3'd2;
  localparam logic [2:0] MODE_SHARP  = 3'd3;
  localparam logic [2:0] MODE_SMOOTH = 3'd4;
  localparam logic [2:0] MODE_ROOT   = 3'd5;
  localparam logic [2:0] MODE_SPHERE = 3'd6;
  localparam logic [2:0] MODE_INVSQ  = 3'd7;

  localparam logic [StrW-1:0] STRENGTH_ONE = 16'd32768;

  // How the falloff factor is formed for one point
  typedef enum logic [1:0] {
    K_CALC,   // computed from the distance
    K_STR,    // strength taken directly
    K_ZERO    // outside the radius
  } kind_e;

  // Point sideband carried down the pipeline
  typedef struct packed {
    logic [2:0][PosW-1:0] p;
    logic [WgtW-1:0]      w;
    kind_e                kind;
  } side_t;

  // Shape candidates riding alongside the second square root
  typedef struct packed {
    logic [15:0] t;
    logic [15:0] t2;
    logic [16:0] sm;
  } shp_t;

endpackage

>>> rtl/hpfd_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module hpfd_sqrt #(
  parameter int IN_W = 40
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [IN_W-1:0]   rad_i,
  output logic [IN_W/2-1:0] root_o
);

  localparam int OutW = IN_W / 2;
  localparam int RemW = OutW + 3;

  logic [RemW-1:0] rem_q  [OutW];
  logic [OutW-1:0] root_q [OutW];
  logic [IN_W-1:0] rad_q  [OutW];

  for (genvar s = 0; s < OutW; s++) begin : g_stage
    logic [RemW-1:0] rem_in;
    logic [RemW-1:0] cmb;
    logic [RemW-1:0] trial;
    logic [OutW-1:0] root_in;
    logic [IN_W-1:0] rad_in;
    logic            ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    // bring down the next two radicand bits and try a one bit
    assign cmb   = {rem_in[RemW-3:0], rad_in[IN_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (cmb >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? (cmb - trial) : cmb;
        root_q[s] <= {root_in[OutW-2:0], ge};
        rad_q[s]  <= rad_in << 2;
      end
    end
  end

  assign root_o = root_q[OutW-1];

endmodule

>>> rtl/hpfd_div.sv
// ----------------------------------------------------------------------------
// Pipelined fraction divider
// Quotient floor(num * 2^(QW-1) / den) for num <= den, one bit per stage.
// ----------------------------------------------------------------------------
module hpfd_div #(
  parameter int DW = 40,
  parameter int QW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW:0]   rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0]   rem_in;
    logic [DW:0]   dif;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = {1'b0, num_i};
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // compare, subtract, shift the partial remainder
    assign ge  = (rem_in >= {1'b0, den_in});
    assign dif = ge ? (rem_in - {1'b0, den_in}) : rem_in;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= dif << 1;
        den_q[s] <= den_in;
        quo_q[s] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

>>> rtl/hook_point_falloff_deform_unit.sv
// ----------------------------------------------------------------------------
// Hook point falloff deform unit
// 64 register stages, one point per cycle while the output is not stalled.
// Depth is set by the distance square root (20 stages), the fraction
// divider (16 stages) and the shape square root (16 stages) plus 12
// arithmetic stages.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset (async, active low) empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
module hook_point_falloff_deform_unit
  import hpfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [IdxW-1:0]      cfg_idx_i,
  input  logic [RegW-1:0]      cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [79:0]          s_axis_tdata,  // point_x, point_y, point_z, point_weight
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata   // moved_x, moved_y, moved_z, zero pad
);

  localparam int Sq1N = 20;
  localparam int DivN = 16;
  localparam int Sq2N = 16;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0]      mode_q;
  logic [RadW-1:0] radius_q;
  logic [StrW-1:0] strength_q;
  logic [RegW-1:0] center_q, rowx_q, rowy_q, rowz_q, offset_q;
  logic [39:0]     r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_NONE;
      radius_q   <= '0;
      strength_q <= STRENGTH_ONE;
      center_q   <= '0;
      rowx_q     <= '0;
      rowy_q     <= '0;
      rowz_q     <= '0;
      offset_q   <= '0;
      r2_q       <= '0;
    end else begin
      r2_q <= radius_q * radius_q;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:     mode_q     <= cfg_data_i[2:0];
          REG_RADIUS:   radius_q   <= cfg_data_i[RadW-1:0];
          REG_STRENGTH: strength_q <= cfg_data_i[StrW-1:0];
          REG_CENTER:   center_q   <= cfg_data_i;
          REG_ROW_X:    rowx_q     <= cfg_data_i;
          REG_ROW_Y:    rowy_q     <= cfg_data_i;
          REG_ROW_Z:    rowz_q     <= cfg_data_i;
          REG_OFFSET:   offset_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // unpack lanes
  logic signed [PosW-1:0] cen [3];
  logic signed [PosW-1:0] off [3];
  logic signed [PosW-1:0] mat [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cen[k]    = center_q[PosW*k +: PosW];
      off[k]    = offset_q[PosW*k +: PosW];
      mat[0][k] = rowx_q[PosW*k +: PosW];
      mat[1][k] = rowy_q[PosW*k +: PosW];
      mat[2][k] = rowz_q[PosW*k +: PosW];
    end
  end

  // --------------------------------------------------------------------------
  // Global advance: the pipeline moves whenever the output slot is free
  // --------------------------------------------------------------------------
  logic adv;
  logic vld_m_q;

  assign adv           = !vld_m_q || m_axis_tready;
  assign s_axis_tready = adv;

  // --------------------------------------------------------------------------
  // Stage A: capture point, subtract center
  // --------------------------------------------------------------------------
  logic               vld_a_q;
  side_t              sd_a_q;
  logic signed [21:0] dif_a_q [3];
  side_t              sd_in;

  always_comb begin
    sd_in.p[0] = s_axis_tdata[20:0];
    sd_in.p[1] = s_axis_tdata[41:21];
    sd_in.p[2] = s_axis_tdata[62:42];
    sd_in.w    = s_axis_tdata[79:63];
    sd_in.kind = K_CALC;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_a_q <= sd_in;
      for (int k = 0; k < 3; k++) begin
        dif_a_q[k] <= {sd_in.p[k][PosW-1], sd_in.p[k]} - {cen[k][PosW-1], cen[k]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: square each difference
  // --------------------------------------------------------------------------
  logic        vld_b_q;
  side_t       sd_b_q;
  logic [43:0] sq_b_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_b_q <= sd_a_q;
      for (int k = 0; k < 3; k++) begin
        sq_b_q[k] <= dif_a_q[k] * dif_a_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: sum to squared distance
  // --------------------------------------------------------------------------
  logic        vld_c_q;
  side_t       sd_c_q;
  logic [45:0] d2_c_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_c_q <= sd_b_q;
      d2_c_q <= {2'b00, sq_b_q[0]} + {2'b00, sq_b_q[1]} + {2'b00, sq_b_q[2]};
    end
  end

  // classify the point and form the inverse-square numerator
  side_t       sd1_in;
  logic [39:0] n7_in;

  always_comb begin
    sd1_in = sd_c_q;
    if (mode_q == MODE_NONE || radius_q == '0) begin
      sd1_in.kind = K_STR;
    end else if (d2_c_q > {6'b0, r2_q}) begin
      sd1_in.kind = K_ZERO;
    end else if (d2_c_q == '0 || mode_q == MODE_CONST) begin
      sd1_in.kind = K_STR;
    end else begin
      sd1_in.kind = K_CALC;
    end
    n7_in = r2_q - d2_c_q[39:0];
  end

  // --------------------------------------------------------------------------
  // Distance square root with aligned sideband
  // --------------------------------------------------------------------------
  logic [19:0] dist_root;
  logic        vld1_q [Sq1N];
  side_t       sd1_q  [Sq1N];
  logic [39:0] n7_q   [Sq1N];

  hpfd_sqrt #(.IN_W(40)) u_sqrt_dist (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (d2_c_q[39:0]),
    .root_o (dist_root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd1_q[0] <= sd1_in;
      n7_q[0]  <= n7_in;
      for (int i = 1; i < Sq1N; i++) begin
        sd1_q[i] <= sd1_q[i-1];
        n7_q[i]  <= n7_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: select divider operands
  // --------------------------------------------------------------------------
  logic        vld_e_q;
  side_t       sd_e_q;
  logic [39:0] num_e_q, den_e_q;
  logic [19:0] dcl;

  assign dcl = (dist_root > radius_q) ? radius_q : dist_root;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_e_q <= sd1_q[Sq1N-1];
      if (mode_q == MODE_INVSQ) begin
        num_e_q <= n7_q[Sq1N-1];
        den_e_q <= r2_q;
      end else begin
        num_e_q <= {20'b0, radius_q - dcl};
        den_e_q <= {20'b0, radius_q};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Fraction divider with aligned sideband
  // --------------------------------------------------------------------------
  logic [15:0] tq;
  logic        vld2_q [DivN];
  side_t       sd2_q  [DivN];

  hpfd_div #(.DW(40), .QW(16)) u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_e_q),
    .den_i (den_e_q),
    .quo_o (tq)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd2_q[0] <= sd_e_q;
      for (int i = 1; i < DivN; i++) begin
        sd2_q[i] <= sd2_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: t squared
  // --------------------------------------------------------------------------
  logic        vld_f_q;
  side_t       sd_f_q;
  logic [15:0] t_f_q, t2_f_q;
  logic [31:0] tt;

  assign tt = {16'b0, tq} * {16'b0, tq};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_f_q <= sd2_q[DivN-1];
      t_f_q  <= tq;
      t2_f_q <= tt[30:15];
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: t cubed
  // --------------------------------------------------------------------------
  logic        vld_g_q;
  side_t       sd_g_q;
  logic [15:0] t_g_q, t2_g_q, t3_g_q;
  logic [31:0] ttt;

  assign ttt = {16'b0, t2_f_q} * {16'b0, t_f_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_g_q <= sd_f_q;
      t_g_q  <= t_f_q;
      t2_g_q <= t2_f_q;
      t3_g_q <= ttt[30:15];
    end
  end

  // root / sphere radicand and smoothstep
  logic [16:0] sph;
  logic [31:0] rad2;
  logic [17:0] smooth;
  shp_t        shp_in;

  always_comb begin
    sph    = {t_g_q, 1'b0} - {1'b0, t2_g_q};
    rad2   = (mode_q == MODE_ROOT) ? {1'b0, t_g_q, 15'b0} : {sph, 15'b0};
    smooth = 18'({2'b00, t2_g_q} * 18'd3) - {1'b0, t3_g_q, 1'b0};
    shp_in.t  = t_g_q;
    shp_in.t2 = t2_g_q;
    shp_in.sm = smooth[16:0];
  end

  // --------------------------------------------------------------------------
  // Shape square root with aligned sideband
  // --------------------------------------------------------------------------
  logic [15:0] root2;
  logic        vld3_q [Sq2N];
  side_t       sd3_q  [Sq2N];
  shp_t        shp_q  [Sq2N];

  hpfd_sqrt #(.IN_W(32)) u_sqrt_shape (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad2),
    .root_o (root2)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd3_q[0] <= sd_g_q;
      shp_q[0] <= shp_in;
      for (int i = 1; i < Sq2N; i++) begin
        sd3_q[i] <= sd3_q[i-1];
        shp_q[i] <= shp_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage H: pick the shape for the mode
  // --------------------------------------------------------------------------
  logic        vld_h_q;
  side_t       sd_h_q;
  logic [16:0] shape_h_q;
  shp_t        shl;

  assign shl = shp_q[Sq2N-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_h_q <= sd3_q[Sq2N-1];
      case (mode_q)
        MODE_SHARP:  shape_h_q <= {1'b0, shl.t2};
        MODE_SMOOTH: shape_h_q <= shl.sm;
        MODE_ROOT,
        MODE_SPHERE: shape_h_q <= {1'b0, root2};
        default:     shape_h_q <= {1'b0, shl.t};
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage I: scale by strength
  // --------------------------------------------------------------------------
  logic        vld_i_q;
  side_t       sd_i_q;
  logic [16:0] fac_i_q;
  logic [32:0] fs;

  assign fs = {16'b0, shape_h_q} * {17'b0, strength_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_i_q <= sd_h_q;
      case (sd_h_q.kind)
        K_STR:   fac_i_q <= {1'b0, strength_q};
        K_ZERO:  fac_i_q <= '0;
        default: fac_i_q <= fs[31:15];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage J: blend factor and matrix products
  // --------------------------------------------------------------------------
  logic               vld_j_q;
  logic               pass_j_q;
  logic [2:0][20:0]   p_j_q;
  logic [17:0]        b_j_q;
  logic signed [41:0] pr_j_q [3][3];
  logic [32:0]        fw;

  assign fw = {16'b0, fac_i_q} * {17'b0, sd_i_q.w[15:0]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pass_j_q <= sd_i_q.w[WgtW-1] || (fac_i_q == '0);
      p_j_q    <= sd_i_q.p;
      b_j_q    <= fw[32:15];
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pr_j_q[k][j] <= mat[k][j] * $signed(sd_i_q.p[j]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage K: row sums and translation
  // --------------------------------------------------------------------------
  logic               vld_k_q;
  logic               pass_k_q;
  logic [2:0][20:0]   p_k_q;
  logic [17:0]        b_k_q;
  logic signed [27:0] q_k_q [3];
  logic signed [43:0] acc [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = 44'(pr_j_q[k][0]) + 44'(pr_j_q[k][1]) + 44'(pr_j_q[k][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pass_k_q <= pass_j_q;
      p_k_q    <= p_j_q;
      b_k_q    <= b_j_q;
      for (int k = 0; k < 3; k++) begin
        q_k_q[k] <= {acc[k][43], acc[k][43:17]} + {{7{off[k][PosW-1]}}, off[k]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage L: scale the move toward the target
  // --------------------------------------------------------------------------
  logic               vld_l_q;
  logic               pass_l_q;
  logic [2:0][20:0]   p_l_q;
  logic signed [47:0] mv_l_q [3];
  logic signed [28:0] e [3];
  logic signed [18:0] bs;

  always_comb begin
    bs = {1'b0, b_k_q};
    for (int k = 0; k < 3; k++) begin
      e[k] = {q_k_q[k][27], q_k_q[k]} - {{8{p_k_q[k][PosW-1]}}, p_k_q[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pass_l_q <= pass_k_q;
      p_l_q    <= p_k_q;
      for (int k = 0; k < 3; k++) begin
        mv_l_q[k] <= e[k] * bs;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage M: add, saturate, hold the result for the output transfer
  // --------------------------------------------------------------------------
  logic [2:0][20:0]   res_m_q;
  logic signed [33:0] sum [3];
  logic [2:0][20:0]   sat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = {mv_l_q[k][47], mv_l_q[k][47:15]} +
               {{13{p_l_q[k][PosW-1]}}, p_l_q[k]};
      if (sum[k] > 34'sd1048575) begin
        sat[k] = 21'h0FFFFF;
      end else if (sum[k] < -34'sd1048576) begin
        sat[k] = 21'h100000;
      end else begin
        sat[k] = sum[k][20:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_m_q <= pass_l_q ? p_l_q : sat;
    end
  end

  assign m_axis_tvalid = vld_m_q;
  assign m_axis_tdata  = {1'b0, res_m_q[2], res_m_q[1], res_m_q[0]};

  // --------------------------------------------------------------------------
  // Valid bits, advancing with the data
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_e_q <= 1'b0;
      vld_f_q <= 1'b0;
      vld_g_q <= 1'b0;
      vld_h_q <= 1'b0;
      vld_i_q <= 1'b0;
      vld_j_q <= 1'b0;
      vld_k_q <= 1'b0;
      vld_l_q <= 1'b0;
      vld_m_q <= 1'b0;
      for (int i = 0; i < Sq1N; i++) vld1_q[i] <= 1'b0;
      for (int i = 0; i < DivN; i++) vld2_q[i] <= 1'b0;
      for (int i = 0; i < Sq2N; i++) vld3_q[i] <= 1'b0;
    end else if (adv) begin
      vld_a_q   <= s_axis_tvalid;
      vld_b_q   <= vld_a_q;
      vld_c_q   <= vld_b_q;
      vld1_q[0] <= vld_c_q;
      for (int i = 1; i < Sq1N; i++) vld1_q[i] <= vld1_q[i-1];
      vld_e_q   <= vld1_q[Sq1N-1];
      vld2_q[0] <= vld_e_q;
      for (int i = 1; i < DivN; i++) vld2_q[i] <= vld2_q[i-1];
      vld_f_q   <= vld2_q[DivN-1];
      vld_g_q   <= vld_f_q;
      vld3_q[0] <= vld_g_q;
      for (int i = 1; i < Sq2N; i++) vld3_q[i] <= vld3_q[i-1];
      vld_h_q   <= vld3_q[Sq2N-1];
      vld_i_q   <= vld_h_q;
      vld_j_q   <= vld_i_q;
      vld_k_q   <= vld_j_q;
      vld_l_q   <= vld_k_q;
      vld_m_q   <= vld_l_q;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_a_q)
    else $error("accepted point did not enter the pipeline");

  a_zero_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld_h_q && (sd_h_q.kind == K_ZERO) |=> (fac_i_q == '0))
    else $error("point outside the radius got a nonzero factor");

  a_shape_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_h_q && (sd_h_q.kind == K_CALC) |-> (shape_h_q <= 17'd32776))
    else $error("falloff shape above one");

endmodule
